### src/acp_pkg.sv
// Shared types and constants of the arithmetic composite pixel unit.
// Holds field widths, fixed-point constants, register indexes and the stage-control structs.
// Depends on nothing; every other file of the block imports it.
package acp_pkg;

  localparam int CHAN_W    = 8;
  localparam int GAIN_W    = 24;
  localparam int NUM_W     = 44;
  localparam int CLIP_W    = 32;
  localparam int QUO_W     = 16;
  localparam int NUM_LANES = 4;
  localparam int IDX_W     = 2;

  localparam int CH_ALPHA = 0;
  localparam int CH_RED   = 1;
  localparam int CH_GREEN = 2;
  localparam int CH_BLUE  = 3;

  localparam logic [IDX_W-1:0] REG_PRODUCT_GAIN = 2'd0;
  localparam logic [IDX_W-1:0] REG_FIRST_GAIN   = 2'd1;
  localparam logic [IDX_W-1:0] REG_SECOND_GAIN  = 2'd2;
  localparam logic [IDX_W-1:0] REG_BIAS_TERM    = 2'd3;

  localparam logic signed [GAIN_W-1:0] RESET_PRODUCT_GAIN = 24'sd0;
  localparam logic signed [GAIN_W-1:0] RESET_FIRST_GAIN   = 24'sd65536;
  localparam logic signed [GAIN_W-1:0] RESET_SECOND_GAIN  = 24'sd0;
  localparam logic signed [GAIN_W-1:0] RESET_BIAS_TERM    = 24'sd0;

  // Full scale is 65536 * 255 * 255; half a code step is 32768 * 255.
  localparam logic signed [CHAN_W:0]     CHAN_MAX_S   = 9'sd255;
  localparam logic signed [NUM_W-1:0]   FULL_SCALE_N = 44'sd4261478400;
  localparam logic [CLIP_W-1:0]         FULL_SCALE   = 32'd4261478400;
  localparam logic [CLIP_W-1:0]         ROUND_HALF   = 32'd8355840;
  localparam logic [QUO_W-1:0]          RECIP_255    = 16'h8081;
  localparam int                        RECIP_SHIFT  = 23;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic load_c;
  } lane_ctl_t;

  typedef struct packed {
    logic load_d;
    logic load_e;
    logic load_f;
  } merge_ctl_t;

endpackage

### src/acp_in_if.sv
// Input channel of the composite unit: a pair of premultiplied ARGB pixels per word.
// Depends on acp_pkg for the channel width.
interface acp_in_if import acp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] first_alpha;
  logic [CHAN_W-1:0] first_red;
  logic [CHAN_W-1:0] first_green;
  logic [CHAN_W-1:0] first_blue;
  logic [CHAN_W-1:0] second_alpha;
  logic [CHAN_W-1:0] second_red;
  logic [CHAN_W-1:0] second_green;
  logic [CHAN_W-1:0] second_blue;

  modport source (
    output valid, first_alpha, first_red, first_green, first_blue,
    output second_alpha, second_red, second_green, second_blue,
    input  ready
  );

  modport sink (
    input  valid, first_alpha, first_red, first_green, first_blue,
    input  second_alpha, second_red, second_green, second_blue,
    output ready
  );
endinterface

### src/acp_out_if.sv
// Output channel of the composite unit: one composited premultiplied ARGB pixel per word.
// Depends on acp_pkg for the channel width.
interface acp_out_if import acp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_alpha;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;

  modport source (
    output valid, out_alpha, out_red, out_green, out_blue,
    input  ready
  );

  modport sink (
    input  valid, out_alpha, out_red, out_green, out_blue,
    output ready
  );
endinterface

### src/acp_lane.sv
// One channel lane: the exact numerator k1*x1*x2 + 255*(k2*x1 + k3*x2 + 255*k4) in three stages.
// Depends on acp_pkg; the top level supplies the stage loads.
module acp_lane import acp_pkg::*; (
  input  logic                     clk,
  input  lane_ctl_t                ctl,
  input  logic [CHAN_W-1:0]        x1,
  input  logic [CHAN_W-1:0]        x2,
  input  logic signed [GAIN_W-1:0] k1,
  input  logic signed [GAIN_W-1:0] k2,
  input  logic signed [GAIN_W-1:0] k3,
  input  logic signed [GAIN_W-1:0] k4,
  output logic signed [NUM_W-1:0]  n
);

  logic [2*CHAN_W-1:0]              pxy;
  logic signed [GAIN_W+CHAN_W:0]    t2;
  logic signed [GAIN_W+CHAN_W:0]    t3;
  logic signed [GAIN_W+CHAN_W:0]    t4;
  logic signed [GAIN_W+2*CHAN_W:0]  m1;
  logic signed [GAIN_W+CHAN_W+2:0]  s;

  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      pxy <= x1 * x2;
      t2  <= k2 * $signed({1'b0, x1});
      t3  <= k3 * $signed({1'b0, x2});
      t4  <= k4 * CHAN_MAX_S;
    end
    if (ctl.load_b) begin
      m1 <= k1 * $signed({1'b0, pxy});
      s  <= (GAIN_W+CHAN_W+3)'(t2) + (GAIN_W+CHAN_W+3)'(t3) + (GAIN_W+CHAN_W+3)'(t4);
    end
    if (ctl.load_c) begin
      n <= NUM_W'(m1) + (NUM_W'(s) <<< CHAN_W) - NUM_W'(s);
    end
  end

endmodule

### src/acp_merge.sv
// Merging stage: clamps alpha, clamps colors to alpha and rounds all four channels to codes.
// Depends on acp_pkg; takes the numerators of the four lanes, alpha first.
module acp_merge import acp_pkg::*; (
  input  logic                    clk,
  input  merge_ctl_t              ctl,
  input  logic signed [NUM_W-1:0] n    [NUM_LANES],
  output logic [CHAN_W-1:0]       code [NUM_LANES]
);

  logic [CLIP_W-1:0]   clip      [NUM_LANES];
  logic [CLIP_W-1:0]   clip_next [NUM_LANES];
  logic [QUO_W-1:0]    quo       [NUM_LANES];
  logic [QUO_W-1:0]    quo_next  [NUM_LANES];
  logic [CLIP_W-1:0]   level     [NUM_LANES];
  logic [CLIP_W-1:0]   rounded   [NUM_LANES];
  logic [2*QUO_W-1:0]  scaled    [NUM_LANES];

  // All four channels are limited to zero and full scale here; the limit to alpha follows next stage.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (n[i] < 0) begin
        clip_next[i] = '0;
      end else if (n[i] > FULL_SCALE_N) begin
        clip_next[i] = FULL_SCALE;
      end else begin
        clip_next[i] = n[i][CLIP_W-1:0];
      end
    end
  end

  // A color above alpha takes alpha; with zero alpha every color becomes zero.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (i != CH_ALPHA && clip[i] > clip[CH_ALPHA]) begin
        level[i] = clip[CH_ALPHA];
      end else begin
        level[i] = clip[i];
      end
      rounded[i]  = level[i] + ROUND_HALF;
      quo_next[i] = rounded[i][CLIP_W-1:CLIP_W-QUO_W];
      scaled[i]   = quo[i] * RECIP_255;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (ctl.load_d) begin
        clip[i] <= clip_next[i];
      end
      if (ctl.load_e) begin
        quo[i] <= quo_next[i];
      end
      if (ctl.load_f) begin
        code[i] <= scaled[i][RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
      end
    end
  end

endmodule

### src/arithmetic_composite_pixel_unit.sv
// Top level of the arithmetic composite pixel unit: gain registers, four lanes, merge, flow control.
// Depends on acp_pkg, acp_in_if, acp_out_if, acp_lane and acp_merge.
//
//   Channel   Direction  Word
//   pix_in    in         first and second ARGB pixel, valid/ready
//   pix_out   out        composited ARGB pixel, valid/ready
//   cfg       in         cfg_write, cfg_index, cfg_data, no handshake
//
// One pixel pair is accepted per clock while pix_out is not stalled, and each passes six register
// stages before its result is offered at pix_out: three lane stages (channel product, gain
// product, scaled sum) and three merge stages (clamp, limit and round, reciprocal multiply for
// the division by 255).
// Reset clears the stage valid bits and loads the gains with their defaults.
// A stall at pix_out holds only the stages that are full, so empty stages keep filling.
module arithmetic_composite_pixel_unit import acp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  acp_in_if.sink                   pix_in,
  acp_out_if.source                pix_out,
  input  logic                     cfg_write,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [GAIN_W-1:0]        cfg_data
);

  localparam int STAGES = 6;

  logic signed [GAIN_W-1:0] product_gain;
  logic signed [GAIN_W-1:0] first_gain;
  logic signed [GAIN_W-1:0] second_gain;
  logic signed [GAIN_W-1:0] bias_term;

  logic [STAGES-1:0]        stage_valid;
  logic [STAGES-1:0]        load;
  lane_ctl_t                lane_ctl;
  merge_ctl_t               merge_ctl;

  logic [CHAN_W-1:0]        lane_x1 [NUM_LANES];
  logic [CHAN_W-1:0]        lane_x2 [NUM_LANES];
  logic signed [NUM_W-1:0]  lane_n  [NUM_LANES];
  logic [CHAN_W-1:0]        code    [NUM_LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      product_gain <= RESET_PRODUCT_GAIN;
      first_gain   <= RESET_FIRST_GAIN;
      second_gain  <= RESET_SECOND_GAIN;
      bias_term    <= RESET_BIAS_TERM;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRODUCT_GAIN: product_gain <= cfg_data;
        REG_FIRST_GAIN:   first_gain   <= cfg_data;
        REG_SECOND_GAIN:  second_gain  <= cfg_data;
        REG_BIAS_TERM:    bias_term    <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    load[STAGES-1] = !stage_valid[STAGES-1] || pix_out.ready;
    for (int i = STAGES-2; i >= 0; i--) begin
      load[i] = !stage_valid[i] || load[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (load[0]) begin
        stage_valid[0] <= pix_in.valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (load[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  assign pix_in.ready = load[0];

  assign lane_ctl.load_a  = load[0];
  assign lane_ctl.load_b  = load[1];
  assign lane_ctl.load_c  = load[2];
  assign merge_ctl.load_d = load[3];
  assign merge_ctl.load_e = load[4];
  assign merge_ctl.load_f = load[5];

  assign lane_x1[CH_ALPHA] = pix_in.first_alpha;
  assign lane_x1[CH_RED]   = pix_in.first_red;
  assign lane_x1[CH_GREEN] = pix_in.first_green;
  assign lane_x1[CH_BLUE]  = pix_in.first_blue;
  assign lane_x2[CH_ALPHA] = pix_in.second_alpha;
  assign lane_x2[CH_RED]   = pix_in.second_red;
  assign lane_x2[CH_GREEN] = pix_in.second_green;
  assign lane_x2[CH_BLUE]  = pix_in.second_blue;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    acp_lane u_lane (
      .clk (clk),
      .ctl (lane_ctl),
      .x1  (lane_x1[g]),
      .x2  (lane_x2[g]),
      .k1  (product_gain),
      .k2  (first_gain),
      .k3  (second_gain),
      .k4  (bias_term),
      .n   (lane_n[g])
    );
  end

  acp_merge u_merge (
    .clk  (clk),
    .ctl  (merge_ctl),
    .n    (lane_n),
    .code (code)
  );

  assign pix_out.valid     = stage_valid[STAGES-1];
  assign pix_out.out_alpha = code[CH_ALPHA];
  assign pix_out.out_red   = code[CH_RED];
  assign pix_out.out_green = code[CH_GREEN];
  assign pix_out.out_blue  = code[CH_BLUE];

endmodule
